FILE: rtl/pdm_demux_pcm_rms_meter_unit_assert.svh
// Assertion macros for the PDM demux / RMS meter unit.
`ifndef PDM_DEMUX_PCM_RMS_METER_UNIT_ASSERT_SVH
`define PDM_DEMUX_PCM_RMS_METER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define PDM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PDM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PDM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/pdm_rms_pkg.sv
// Shared constants for the PDM demux / RMS meter unit.
`default_nettype none

package pdm_rms_pkg;

    localparam int FRAME_SAMPLES  = 256;   // must be a power of two
    localparam int CHANNELS       = 4;
    localparam int PCM_FULL_SCALE = 4096;
    localparam int PDM_BITS       = 8;

    localparam int PDM_W   = 8;
    localparam int MIC_W   = 2;
    localparam int PCM_W   = 14;
    localparam int RMS_W   = 17;

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMP_W     = $clog2(FRAME_SAMPLES);
    localparam int FRAME_LOG2 = $clog2(FRAME_SAMPLES);
    localparam int ONES_W     = $clog2(PDM_BITS + 1);
    localparam int DIFF_W     = ONES_W + 1;
    localparam int SQ_W       = $clog2(PDM_BITS * PDM_BITS + 1);
    localparam int PCM_SHIFT  = $clog2(PCM_FULL_SCALE / PDM_BITS);

    // accumulator holds sum of (ones - zeros)^2; the PCM scale is applied later
    localparam int ACC_W     = $clog2(FRAME_SAMPLES * PDM_BITS * PDM_BITS + 1);
    // energy * 256 / FRAME_SAMPLES as a left shift of the raw sum
    localparam int RAD_SHIFT = 2 * PCM_SHIFT + 8 - FRAME_LOG2;
    localparam int RAD_W     = ACC_W + RAD_SHIFT;
    localparam int ROOT_W    = (RAD_W + 1) / 2;
    localparam int PAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int ITER_W    = $clog2(ROOT_W);

endpackage

`default_nettype wire

FILE: rtl/pdm_rms_if.sv
// Input and output channel interfaces for the PDM demux / RMS meter unit.
`default_nettype none

interface pdm_rms_in_if import pdm_rms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PDM_W-1:0] pdm_bits;

    modport source (output valid, output pdm_bits, input ready);
    modport sink   (input valid, input pdm_bits, output ready);
endinterface

interface pdm_rms_out_if import pdm_rms_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MIC_W-1:0]        mic_index;
    logic signed [PCM_W-1:0] pcm_sample;
    logic                    rms_valid;
    logic [RMS_W-1:0]        rms_level;
    logic                    frame_last;

    modport source (output valid, output mic_index, output pcm_sample, output rms_valid,
                    output rms_level, output frame_last, input ready);
    modport sink   (input valid, input mic_index, input pcm_sample, input rms_valid,
                    input rms_level, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/pdm_rms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pdm_rms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/pdm_rms_sqrt.sv
// Bit-serial floor square root, one result bit per cycle.
`default_nettype none

module pdm_rms_sqrt import pdm_rms_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [PAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              take;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // remainder stays below 2*root, so its top two bits are free before the shift
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[PAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        take      = (rem_shift >= trial);
        rem_next  = take ? (rem_shift - trial) : rem_shift;
        root_next = {root_reg[ROOT_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == ITER_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= PAD_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

FILE: rtl/pdm_demux_pcm_rms_meter_unit.sv
// Top level of the PDM demux with per-microphone PCM output and RMS level meter.
//
// Input channel in_ch carries one PDM byte (8 bits, MSB first) per item, the
// microphones interleaved in turn starting with microphone 0. Every accepted
// item gives exactly one output item on out_ch: the microphone index, the PCM
// sample ((ones - zeros) * 512), and on the last sampling instant of a frame
// the microphone's RMS level (4 fractional bits) with rms_valid set. The last
// byte of the whole frame also raises frame_last.
// Per-microphone energy sums live in a small RAM (registered read), read at
// accept, updated and written back in the next cycle; one item is in flight.
// An ordinary item passes the accumulate and output states on its way to
// out_ch, and no new item is taken until the block is back in idle. An item
// that closes a microphone's frame also runs the 17-step serial square root
// between those two states before its result is registered on out_ch.
// The output register lets the next item be accepted while a result waits;
// that next item then holds in its final step until the receiver takes the
// waiting result. Reset clears the counters and marks all sums empty (an
// empty sum reads as zero), so the block accepts items right after reset.
`default_nettype none

module pdm_demux_pcm_rms_meter_unit import pdm_rms_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    pdm_rms_in_if.sink          in_ch,
    pdm_rms_out_if.source       out_ch
);

`include "pdm_demux_pcm_rms_meter_unit_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACC  = 4'b0010,
        S_SQRT = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CH_W-1:0]         chan_reg;
    logic [SAMP_W-1:0]       samp_reg;
    logic [CHANNELS-1:0]     acc_vld_reg;

    // item in flight
    logic [CH_W-1:0]         mic_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic                    last_inst_reg;
    logic                    frame_last_reg;
    logic [RMS_W-1:0]        rms_reg;

    // output register
    logic                    out_valid_reg;
    logic [MIC_W-1:0]        out_mic_reg;
    logic signed [PCM_W-1:0] out_pcm_reg;
    logic                    out_rms_valid_reg;
    logic [RMS_W-1:0]        out_rms_reg;
    logic                    out_frame_last_reg;

    logic                    accept;
    logic                    last_mic;
    logic                    last_inst;
    logic [ONES_W-1:0]       ones_cnt;
    logic [DIFF_W-1:0]       diff_next;
    logic [DIFF_W-1:0]       mag;
    logic [SQ_W-1:0]         sq;
    logic [ACC_W-1:0]        acc_rd;
    logic [ACC_W-1:0]        acc_old;
    logic [ACC_W-1:0]        acc_sum;
    logic                    acc_wr;
    logic [RAD_W-1:0]        radicand;
    logic                    sq_start;
    logic                    sq_done;
    logic [ROOT_W-1:0]       sq_root;
    logic                    out_free;

    assign accept    = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign last_mic  = (chan_reg >= CH_W'(CHANNELS - 1));
    assign last_inst = (samp_reg >= SAMP_W'(FRAME_SAMPLES - 1));
    assign out_free  = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        ones_cnt = '0;
        for (int b = 0; b < PDM_BITS; b++)
        begin
            ones_cnt = ones_cnt + ONES_W'(in_ch.pdm_bits[b]);
        end
        diff_next = {ones_cnt, 1'b0} - DIFF_W'(PDM_BITS);
    end

    // read-modify-write of the per-microphone sum; the FSM keeps one access open
    always_comb
    begin
        mag      = diff_reg[DIFF_W-1] ? (~diff_reg + 1'b1) : diff_reg;
        sq       = SQ_W'(mag * mag);
        acc_old  = acc_vld_reg[mic_reg] ? acc_rd : '0;
        acc_sum  = acc_old + ACC_W'(sq);
        acc_wr   = (state_reg == S_ACC);
        radicand = RAD_W'(acc_sum) << RAD_SHIFT;
        sq_start = acc_wr && last_inst_reg;
    end

    pdm_rms_ram #(
        .WIDTH (ACC_W),
        .DEPTH (CHANNELS)
    ) u_acc_ram (
        .clk     (clk),
        .wr_en   (acc_wr),
        .wr_addr (mic_reg),
        .wr_data (last_inst_reg ? '0 : acc_sum),
        .rd_en   (accept),
        .rd_addr (chan_reg),
        .rd_data (acc_rd)
    );

    pdm_rms_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (radicand),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_ACC;
            S_ACC:   state_next = last_inst_reg ? S_SQRT : S_OUT;
            S_SQRT:  if (sq_done) state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chan_reg      <= '0;
            samp_reg      <= '0;
            acc_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (last_mic)
                begin
                    chan_reg <= '0;
                    samp_reg <= last_inst ? '0 : samp_reg + 1'b1;
                end
                else
                begin
                    chan_reg <= chan_reg + 1'b1;
                end
            end
            if (acc_wr)
            begin
                acc_vld_reg[mic_reg] <= 1'b1;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mic_reg        <= chan_reg;
            diff_reg       <= diff_next;
            last_inst_reg  <= last_inst;
            frame_last_reg <= last_inst && last_mic;
        end
        if (acc_wr)
        begin
            rms_reg <= '0;
        end
        else if (state_reg == S_SQRT && sq_done)
        begin
            rms_reg <= RMS_W'(sq_root);
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_mic_reg        <= MIC_W'(mic_reg);
            out_pcm_reg        <= PCM_W'(diff_reg) <<< PCM_SHIFT;
            out_rms_valid_reg  <= last_inst_reg;
            out_rms_reg        <= rms_reg;
            out_frame_last_reg <= frame_last_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.mic_index  = out_mic_reg;
    assign out_ch.pcm_sample = out_pcm_reg;
    assign out_ch.rms_valid  = out_rms_valid_reg;
    assign out_ch.rms_level  = out_rms_reg;
    assign out_ch.frame_last = out_frame_last_reg;

    `PDM_ASSERT_NEXT(a_accept_to_acc, clk, rst_n, accept, state_reg == S_ACC)
    `PDM_ASSERT_IMP(a_sqrt_done_in_sqrt, clk, rst_n, sq_done, state_reg == S_SQRT)
    `PDM_ASSERT_IMP(a_rms_zero_when_invalid, clk, rst_n, out_valid_reg && !out_rms_valid_reg,
                    out_rms_reg == '0)
    `PDM_ASSERT_IMP(a_frame_last_has_rms, clk, rst_n, out_valid_reg && out_frame_last_reg,
                    out_rms_valid_reg)

endmodule

`default_nettype wire
